[rtl/core/dm3_pkg.sv]
// Shared constants, types and a function of the distance median-of-three filter.
package dm3_pkg;

  localparam int NUM_CH  = 5;
  localparam int CH_W    = 3;
  localparam int ADC_W   = 10;
  localparam int DIST_W  = 8;
  localparam int Q_W     = 9;
  localparam int REM_W   = 26;
  localparam int DEN_W   = 22;
  localparam int DSH_W   = DEN_W + Q_W - 1;
  localparam int STEP_W  = 4;
  localparam int IN_W    = NUM_CH * ADC_W;
  localparam int IN_PAD_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = NUM_CH * DIST_W;
  localparam int ADDR_W  = 3;

  // distance = floor((42709704 - 30150*adc) / (2500*adc + 91600))
  localparam logic [REM_W-1:0] NUM_BASE  = 26'd42709704;
  localparam logic [REM_W-1:0] NUM_SLOPE = 26'd30150;
  localparam logic [DEN_W-1:0] DEN_BASE  = 22'd91600;
  localparam logic [DEN_W-1:0] DEN_SLOPE = 22'd2500;

  localparam logic [DIST_W-1:0] MAXD_RESET = 8'd150;
  localparam logic [ADDR_W-1:0] ADDR_MAX_DIST = 3'd0;
  localparam logic [CH_W-1:0]   LAST_CH = 3'(NUM_CH - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = 4'(Q_W - 1);

  typedef struct packed {
    logic            load_in;
    logic            load_ch;
    logic            div_step;
    logic            finish_ch;
    logic            publish;
    logic [CH_W-1:0] ch;
  } dm3_cmd_t;

  typedef struct packed {
    logic out_free;
  } dm3_status_t;

  function automatic logic [DIST_W-1:0] median3(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b,
                                                input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      median3 = lo;
    end else if (c >= hi) begin
      median3 = hi;
    end else begin
      median3 = c;
    end
  endfunction

endpackage

[rtl/core/distance_median3_filter.sv]
// Five-channel infrared range converter to distance, with per-channel median of three.
// One item is a scan of five 10-bit readings; each becomes a distance in cm by
// floor(8762.88/(adc/2+18.32) - 12.06), computed exactly, clamped to max_distance,
// and the result item carries the median of the last three distances per channel
// (history cleared to zero at reset). Each item is accepted, then per channel
// loaded into the single shared restoring divider (one quotient bit a cycle),
// divided to a nine-bit quotient and finished into the median history, then
// published once the output register is free. The next item is accepted in the
// cycle after publish, while the previous result may still wait in the output
// register. max_distance is at byte address 0 of the register port, reset 150.
module distance_median3_filter
  import dm3_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_PAD_W-1:0] in_tdata,   // adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, pad
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // dist_ch0, dist_ch1, dist_ch2, dist_ch3, dist_ch4
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dm3_cmd_t          cmd;
  dm3_status_t       status;
  logic [DIST_W-1:0] max_dist_r;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_DIST) ? {24'd0, max_dist_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAXD_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_DIST) begin
      max_dist_r <= pwdata[DIST_W-1:0];
    end
  end

  dm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dm3_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata[IN_W-1:0]),
    .max_dist  (max_dist_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

[rtl/core/dm3_ctrl.sv]
// Sequencer stepping the shared divider over the five channels of one scan item.
module dm3_ctrl
  import dm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  dm3_status_t status,
  output dm3_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_PUB  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.ch        = ch_r;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          ch_nxt      = '0;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_ch = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_FIN: begin
        cmd.finish_ch = 1'b1;
        if (ch_r == LAST_CH) begin
          state_nxt = S_PUB;
        end else begin
          ch_nxt    = ch_r + 3'd1;
          state_nxt = S_LOAD;
        end
      end
      S_PUB: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[rtl/core/dm3_datapath.sv]
// Conversion divider, clamp, median history and output register.
module dm3_datapath
  import dm3_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dm3_cmd_t            cmd,
  output dm3_status_t         status,
  input  logic [IN_W-1:0]     in_data,
  input  logic [DIST_W-1:0]   max_dist,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_data
);

  logic [ADC_W-1:0]  adc_r   [NUM_CH];
  logic [DIST_W-1:0] older_r [NUM_CH];
  logic [DIST_W-1:0] newer_r [NUM_CH];
  logic [DIST_W-1:0] res_r   [NUM_CH];
  logic [REM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [Q_W-1:0]    q_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [ADC_W-1:0]  adc_sel;
  logic [REM_W-1:0]  num_ld;
  logic [DEN_W-1:0]  den_ld;
  logic              ge;
  logic [DIST_W-1:0] cur;
  logic [DIST_W-1:0] med;
  logic [OUT_W-1:0]  res_flat;

  assign adc_sel = adc_r[cmd.ch];
  assign num_ld  = NUM_BASE - NUM_SLOPE * REM_W'(adc_sel);
  assign den_ld  = DEN_SLOPE * DEN_W'(adc_sel) + DEN_BASE;
  assign ge      = {{(DSH_W-REM_W){1'b0}}, rem_r} >= dsh_r;
  assign cur     = (q_r > {1'b0, max_dist}) ? max_dist : q_r[DIST_W-1:0];
  assign med     = median3(older_r[cmd.ch], newer_r[cmd.ch], cur);

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      res_flat[i*DIST_W +: DIST_W] = res_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < NUM_CH; i++) begin
        adc_r[i] <= in_data[i*ADC_W +: ADC_W];
      end
    end
    if (cmd.load_ch) begin
      rem_r <= num_ld;
      dsh_r <= {den_ld, {(Q_W-1){1'b0}}};
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[REM_W-1:0];
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
    if (cmd.finish_ch) begin
      res_r[cmd.ch] <= med;
    end
    if (cmd.publish) begin
      out_data_r <= res_flat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        older_r[i] <= '0;
        newer_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish_ch) begin
        older_r[cmd.ch] <= newer_r[cmd.ch];
        newer_r[cmd.ch] <= cur;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

[rtl/core/dm3_checker.sv]
// Port-level checks of the distance median-of-three filter, bound to the top level.
module dm3_checker
  import dm3_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_W-1:0]    out_tdata,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ADDR_W-1:0]   paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item still in work");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr == ADDR_MAX_DIST) ##1
    (paddr == ADDR_MAX_DIST) |-> prdata == {24'd0, $past(pwdata[DIST_W-1:0])})
    else $error("max_distance readback mismatch");

  a_no_result_while_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result item appeared without work");

endmodule

bind distance_median3_filter dm3_checker u_dm3_checker (.*);
